FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point ALU.
// No dependencies; the top level, front end and back end import this package.
package fpa_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int WORD_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int MUL_CHUNK_BITS = 16;

   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_CMP = 3'd4;
   localparam logic [2:0] FUNC_INC = 3'd5;
   localparam logic [2:0] FUNC_DEC = 3'd6;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_word;
      logic               greater;
      logic               less;
      logic               equal;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_type;

   // Classification handed from the front end to the execution back end.
   typedef struct packed {
      logic sel_mul;
      logic sel_div;
      logic neg;
      logic greater;
      logic less;
      logic equal;
      logic overflow;
      logic divide_by_zero;
   } ctl_type;

endpackage

FILE: rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Top level of the signed fixed-point ALU: front end, decoupling queue,
// execution back end and result queue. Depends on fpa_pkg and submodules.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   request | req_push, req_full, req_data   | beat taken: push && !full
//   result  | rsp_pop, rsp_empty, rsp_data   | beat taken: pop && !empty
//
// One beat per cycle sustained for every operation while the result queue
// has room. The pipe depth is set by the divider, which resolves one
// quotient bit per stage; all operations ride the same pipe.
// Reset clears the queue pointers and counts and the pipe valid bits only.
// A full result queue stalls the whole pipe once a finished beat waits;
// the request queue keeps taking beats until it fills.
module fixed_point_alu #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  fpa_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output fpa_pkg::rsp_type rsp_data
);
   import fpa_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $bits(ctl_type);
   localparam int QW = CW + 3 * W;
   localparam int RW = $bits(rsp_type);

   // Classify the incoming beat.
   ctl_type      f_ctl;
   logic [W-1:0] f_mag_a, f_mag_b, f_simple;

   fpa_front #(.WORD_BITS(W)) u_front (
      .req         (req_data),
      .ctl         (f_ctl),
      .mag_a       (f_mag_a),
      .mag_b       (f_mag_b),
      .simple_word (f_simple)
   );

   // Hold classified beats between the two halves.
   logic [QW-1:0] q_rdata;
   logic          q_empty, q_pop;

   fpa_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_work_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata ({f_ctl, f_mag_a, f_mag_b, f_simple}),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // Execute.
   logic    b_push, r_full;
   rsp_type b_rsp;

   fpa_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (q_empty),
      .in_pop    (q_pop),
      .in_ctl    (ctl_type'(q_rdata[QW-1 -: CW])),
      .in_mag_a  (q_rdata[3*W-1 -: W]),
      .in_mag_b  (q_rdata[2*W-1 -: W]),
      .in_simple (q_rdata[W-1:0]),
      .out_full  (r_full),
      .out_push  (b_push),
      .out_rsp   (b_rsp)
   );

   // Park finished results until the consumer pops them.
   logic [RW-1:0] r_rdata;

   fpa_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (b_push),
      .wdata (b_rsp),
      .full  (r_full),
      .pop   (rsp_pop),
      .rdata (r_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(r_rdata);

endmodule

FILE: rtl/fpa_queue.sv
`timescale 1ns / 1ps
// Small register-based first-in first-out queue.
// Depends on nothing but its parameters.
module fpa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/fpa_front.sv
`timescale 1ns / 1ps
// Front end: decodes a beat, forms operand magnitudes and finishes
// add, sub, inc, dec, compare and divide by zero. Depends on fpa_pkg.
module fpa_front #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
   input  fpa_pkg::req_type      req,
   output fpa_pkg::ctl_type      ctl,
   output logic [WORD_BITS-1:0]  mag_a,
   output logic [WORD_BITS-1:0]  mag_b,
   output logic [WORD_BITS-1:0]  simple_word
);
   import fpa_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] a, b, sum, diff, sat;
   logic         na, nb, a_lt_b;

   always_comb begin
      a      = W'(req.operand_a);
      b      = W'(req.operand_b);
      na     = a[W-1];
      nb     = b[W-1];
      mag_a  = na ? (~a + 1'b1) : a;
      mag_b  = nb ? (~b + 1'b1) : b;
      sum    = a + b;
      diff   = a - b;
      sat    = na ? MIN_WORD : MAX_WORD;
      a_lt_b = $signed(a) < $signed(b);

      ctl         = '0;
      simple_word = '0;
      case (req.func)
         FUNC_ADD: begin
            if (na == nb && sum[W-1] != na) begin
               ctl.overflow = 1'b1;
               simple_word  = sat;
            end else begin
               simple_word  = sum;
            end
         end
         FUNC_SUB: begin
            if (na != nb && diff[W-1] != na) begin
               ctl.overflow = 1'b1;
               simple_word  = sat;
            end else begin
               simple_word  = diff;
            end
         end
         FUNC_MUL: begin
            ctl.sel_mul = 1'b1;
            ctl.neg     = na ^ nb;
         end
         FUNC_DIV: begin
            if (b == '0) begin
               ctl.divide_by_zero = 1'b1;
               simple_word        = (a == '0) ? '0 : sat;
            end else begin
               ctl.sel_div = 1'b1;
               ctl.neg     = na ^ nb;
            end
         end
         FUNC_CMP: begin
            ctl.equal   = (a == b);
            ctl.less    = a_lt_b;
            ctl.greater = !a_lt_b && (a != b);
         end
         FUNC_INC: begin
            ctl.overflow = (a == MAX_WORD);
            simple_word  = (a == MAX_WORD) ? a : a + 1'b1;
         end
         FUNC_DEC: begin
            ctl.overflow = (a == MIN_WORD);
            simple_word  = (a == MIN_WORD) ? a : a - 1'b1;
         end
         default: begin
            ctl         = '0;
            simple_word = '0;
         end
      endcase
   end

endmodule

FILE: rtl/fpa_back.sv
`timescale 1ns / 1ps
// Back end: one restoring-division step per stage, chunked multiply in the
// first stages, then rounding and saturation. Depends on fpa_pkg.
module fpa_back #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_empty,
   output logic                  in_pop,
   input  fpa_pkg::ctl_type      in_ctl,
   input  logic [WORD_BITS-1:0]  in_mag_a,
   input  logic [WORD_BITS-1:0]  in_mag_b,
   input  logic [WORD_BITS-1:0]  in_simple,
   input  logic                  out_full,
   output logic                  out_push,
   output fpa_pkg::rsp_type      out_rsp
);
   import fpa_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int QB  = W + F;
   localparam int PW  = 2 * W;
   localparam int MW  = 2 * W + 1;
   localparam int CH  = MUL_CHUNK_BITS;
   localparam int NCH = (W + CH - 1) / CH;
   localparam logic [MW-1:0] HALF    = (MW'(1) << F) >> 1;
   localparam logic [MW-1:0] MAX_MAG = (MW'(1) << (W - 1)) - 1'b1;
   localparam logic [MW-1:0] MIN_MAG = MW'(1) << (W - 1);
   localparam logic [W-1:0]  MAX_WORD = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MIN_WORD = {1'b1, {(W-1){1'b0}}};

   logic          v_ff   [0:QB];
   ctl_type       ctl_ff [0:QB];
   logic [W-1:0]  ma_ff  [0:QB];
   logic [W-1:0]  mb_ff  [0:QB];
   logic [W-1:0]  sw_ff  [0:QB];
   logic [W:0]    rem_ff [0:QB];
   logic [QB-1:0] x_ff   [0:QB];
   logic [PW-1:0] p_ff   [0:QB];

   logic          en;

   // Rounding stage.
   logic          r_v_ff;
   ctl_type       r_ctl_ff;
   logic [W-1:0]  r_sw_ff;
   logic [MW-1:0] r_mag_ff, r_mag_in;

   // Advance the whole pipe unless the finished beat cannot leave.
   assign en       = !(r_v_ff && out_full);
   assign in_pop   = en && !in_empty;
   assign out_push = en && r_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= !in_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= in_ctl;
         ma_ff[0]  <= in_mag_a;
         mb_ff[0]  <= in_mag_b;
         sw_ff[0]  <= in_simple;
         rem_ff[0] <= '0;
         x_ff[0]   <= QB'(in_mag_a) << F;
         p_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [W:0]    rem_sh, rem_in;
      logic          ge;
      logic [PW-1:0] p_in;

      always_comb begin
         rem_sh = {rem_ff[k][W-1:0], x_ff[k][QB-1]};
         ge     = rem_sh >= {1'b0, mb_ff[k]};
         rem_in = ge ? rem_sh - {1'b0, mb_ff[k]} : rem_sh;
      end

      if (k < NCH) begin : g_mul
         logic [W+CH-1:0] pp;
         assign pp   = ma_ff[k] * CH'(mb_ff[k] >> (CH * k));
         assign p_in = p_ff[k] + (PW'(pp) << (CH * k));
      end else begin : g_pass
         assign p_in = p_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[k+1] <= ctl_ff[k];
            ma_ff[k+1]  <= ma_ff[k];
            mb_ff[k+1]  <= mb_ff[k];
            sw_ff[k+1]  <= sw_ff[k];
            rem_ff[k+1] <= rem_in;
            x_ff[k+1]   <= {x_ff[k][QB-2:0], ge};
            p_ff[k+1]   <= p_in;
         end
      end
   end

   // Round: product adds half an output step; quotient rounds up when the
   // remainder reaches half the divisor.
   always_comb begin
      if (ctl_ff[QB].sel_mul) begin
         r_mag_in = ({1'b0, p_ff[QB]} + HALF) >> F;
      end else begin
         r_mag_in = MW'(x_ff[QB])
                  + MW'({rem_ff[QB][W-1:0], 1'b0} >= {1'b0, mb_ff[QB]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (en) begin
         r_v_ff <= v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ctl_ff <= ctl_ff[QB];
         r_sw_ff  <= sw_ff[QB];
         r_mag_ff <= r_mag_in;
      end
   end

   // Saturate and apply the sign.
   logic         sat;
   logic [W-1:0] word;

   always_comb begin
      sat  = r_mag_ff > (r_ctl_ff.neg ? MIN_MAG : MAX_MAG);
      word = r_sw_ff;
      if (r_ctl_ff.sel_mul || r_ctl_ff.sel_div) begin
         if (sat) begin
            word = r_ctl_ff.neg ? MIN_WORD : MAX_WORD;
         end else begin
            word = r_ctl_ff.neg ? (~r_mag_ff[W-1:0] + 1'b1) : r_mag_ff[W-1:0];
         end
      end
      out_rsp.result_word    = 32'(signed'(word));
      out_rsp.greater        = r_ctl_ff.greater;
      out_rsp.less           = r_ctl_ff.less;
      out_rsp.equal          = r_ctl_ff.equal;
      out_rsp.overflow       = r_ctl_ff.overflow
                             || ((r_ctl_ff.sel_mul || r_ctl_ff.sel_div) && sat);
      out_rsp.divide_by_zero = r_ctl_ff.divide_by_zero;
   end

endmodule
